### sv/ea2rm_pkg.sv
// Shared types, constants and tables of the Euler angle to rotation matrix block.
`timescale 1ns / 1ps
package ea2rm_pkg;

	localparam int ANGLE_W = 16;
	localparam int OUT_W   = 16;
	localparam int ORDER_W = 3;

	// Angles are in 1/128 degree steps; a half turn is 23040 and a quarter 11520.
	localparam int ANGLE_LIMIT   = 23040;
	localparam int QUARTER_LIMIT = 11520;
	localparam int MAG_W         = 14;
	localparam int ANG_EXT_W     = ANGLE_W + 1;

	// Radian conversion: mag * PI_Q30 / 23040 split as mag * RAD_A plus the
	// rounded quotient of mag * RAD_B, with PI_Q30 = 23040 * RAD_A + RAD_B.
	localparam int RAD_A_W     = 18;
	localparam int RAD_B_W     = 15;
	localparam int RAD_P_W     = 32;
	localparam int RAD_T_W     = 28;
	localparam int RAD_N_W     = 19;
	localparam int RECIP_W     = 26;
	localparam int RAD_Q_W     = 14;
	localparam int RAD_PRE_SHIFT = 9;
	localparam int RECIP_SHIFT   = 31;
	localparam logic [RAD_A_W-1:0] RAD_A    = 18'd146408;
	localparam logic [RAD_B_W-1:0] RAD_B    = 15'd19106;
	localparam logic [RAD_T_W-1:0] RAD_HALF = 28'd11520;
	// Ceiling of 2^31 / 45; exact for every numerator below 2^19.
	localparam logic [RECIP_W-1:0] RECIP45  = 26'd47721859;

	// Q30 datapath values carry a few guard bits above plus and minus one.
	localparam int Q_W      = 33;
	localparam int Q_FRAC   = 30;
	localparam int PROD_W   = 2 * Q_W;
	localparam int ACC_W    = PROD_W + 2;
	localparam int ATAN_W   = 30;
	localparam int ATAN_LEN = 24;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int OUT_FRAC_BITS_DEF = 14;

	typedef logic signed [Q_W-1:0] q30_t;
	typedef q30_t mat_t [3][3];

	localparam q30_t GAIN_Q30 = 33'sd652032874;
	localparam q30_t ONE_Q30  = 33'sd1073741824;

	typedef enum logic [ORDER_W-1:0] {
		ORD_ZYX = 3'd0,
		ORD_YZX = 3'd1,
		ORD_ZXY = 3'd2,
		ORD_XZY = 3'd3,
		ORD_YXZ = 3'd4,
		ORD_XYZ = 3'd5
	} order_t;

	function automatic logic [ATAN_W-1:0] atan_q30(input int unsigned idx);
		logic [ATAN_W-1:0] v;
		unique case (idx)
			0:  v = 30'd843314857;
			1:  v = 30'd497837829;
			2:  v = 30'd263043837;
			3:  v = 30'd133525159;
			4:  v = 30'd67021687;
			5:  v = 30'd33543516;
			6:  v = 30'd16775851;
			7:  v = 30'd8388437;
			8:  v = 30'd4194283;
			9:  v = 30'd2097149;
			10: v = 30'd1048576;
			11: v = 30'd524288;
			12: v = 30'd262144;
			13: v = 30'd131072;
			14: v = 30'd65536;
			15: v = 30'd32768;
			16: v = 30'd16384;
			17: v = 30'd8192;
			18: v = 30'd4096;
			19: v = 30'd2048;
			20: v = 30'd1024;
			21: v = 30'd512;
			22: v = 30'd256;
			23: v = 30'd128;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### sv/ea2rm_ifs.sv
// Handshake interfaces for the angle input, the matrix output and the order register.
`timescale 1ns / 1ps
interface ea2rm_angle_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [ea2rm_pkg::ANGLE_W-1:0]   angle_x;
	logic signed [ea2rm_pkg::ANGLE_W-1:0]   angle_y;
	logic signed [ea2rm_pkg::ANGLE_W-1:0]   angle_z;
	modport source (output valid, angle_x, angle_y, angle_z, input ready);
	modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface ea2rm_matrix_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ea2rm_pkg::OUT_W-1:0]   m00;
	logic signed [ea2rm_pkg::OUT_W-1:0]   m01;
	logic signed [ea2rm_pkg::OUT_W-1:0]   m02;
	logic signed [ea2rm_pkg::OUT_W-1:0]   m10;
	logic signed [ea2rm_pkg::OUT_W-1:0]   m11;
	logic signed [ea2rm_pkg::OUT_W-1:0]   m12;
	logic signed [ea2rm_pkg::OUT_W-1:0]   m20;
	logic signed [ea2rm_pkg::OUT_W-1:0]   m21;
	logic signed [ea2rm_pkg::OUT_W-1:0]   m22;
	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready);
endinterface

interface ea2rm_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [ea2rm_pkg::ORDER_W-1:0]     rotation_order;
	modport source (output valid, rotation_order, input ready);
	modport sink (input valid, rotation_order, output ready);
endinterface

### sv/ea2rm_rad.sv
// Three-stage angle saturation, half-turn fold and conversion to Q30 radians.
`timescale 1ns / 1ps
module ea2rm_rad (
	input  logic                                 clk,
	input  logic [2:0]                           en,
	input  logic signed [ea2rm_pkg::ANGLE_W-1:0] angle,
	output ea2rm_pkg::q30_t                      z,
	output logic                                 flip
);
	import ea2rm_pkg::*;

	logic signed [ANG_EXT_W-1:0] sat, fold;
	logic                        fold_flip;

	logic [MAG_W-1:0]   mag_s1;
	logic               neg_s1, flip_s1;
	logic [RAD_P_W-1:0] p_s2;
	logic [RAD_T_W-1:0] t_s2;
	logic               neg_s2, flip_s2;
	q30_t               z_s3;
	logic               flip_s3;

	logic [RAD_N_W-1:0]           num;
	logic [RAD_N_W+RECIP_W-1:0]   quot_full;
	logic [RAD_P_W:0]             sum;

	always_comb begin
		sat = ANG_EXT_W'(angle);
		if (sat > ANG_EXT_W'(ANGLE_LIMIT)) begin
			sat = ANG_EXT_W'(ANGLE_LIMIT);
		end else if (sat < -ANG_EXT_W'(ANGLE_LIMIT)) begin
			sat = -ANG_EXT_W'(ANGLE_LIMIT);
		end
		// Beyond a quarter turn the angle moves a half turn toward zero and the
		// sine and cosine change sign at the end.
		fold_flip = 1'b1;
		if (sat > ANG_EXT_W'(QUARTER_LIMIT)) begin
			fold = sat - ANG_EXT_W'(ANGLE_LIMIT);
		end else if (sat < -ANG_EXT_W'(QUARTER_LIMIT)) begin
			fold = sat + ANG_EXT_W'(ANGLE_LIMIT);
		end else begin
			fold      = sat;
			fold_flip = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			mag_s1  <= fold[ANG_EXT_W-1] ? MAG_W'(-fold) : MAG_W'(fold);
			neg_s1  <= fold[ANG_EXT_W-1];
			flip_s1 <= fold_flip;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p_s2    <= RAD_P_W'(mag_s1 * RAD_A);
			t_s2    <= RAD_T_W'(mag_s1 * RAD_B) + RAD_HALF;
			neg_s2  <= neg_s1;
			flip_s2 <= flip_s1;
		end
	end

	// Divide by 23040 as a shift by nine and a reciprocal multiply for 45.
	always_comb begin
		num       = t_s2[RAD_T_W-1:RAD_PRE_SHIFT];
		quot_full = num * RECIP45;
		sum       = {1'b0, p_s2} + (RAD_P_W+1)'(quot_full[RECIP_SHIFT +: RAD_Q_W]);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			z_s3    <= neg_s2 ? -$signed(Q_W'(sum)) : $signed(Q_W'(sum));
			flip_s3 <= flip_s2;
		end
	end

	assign z    = z_s3;
	assign flip = flip_s3;

endmodule

### sv/ea2rm_cordic.sv
// Pipelined rotation-mode CORDIC, one register stage per iteration plus a sign fix stage.
`timescale 1ns / 1ps
module ea2rm_cordic #(
	parameter int CORDIC_STAGES = ea2rm_pkg::CORDIC_STAGES_DEF
) (
	input  logic                   clk,
	input  logic [CORDIC_STAGES:0] en,
	input  ea2rm_pkg::q30_t        z_in,
	input  logic                   flip_in,
	output ea2rm_pkg::q30_t        sin_out,
	output ea2rm_pkg::q30_t        cos_out
);
	import ea2rm_pkg::*;

	q30_t x_sk [CORDIC_STAGES];
	q30_t y_sk [CORDIC_STAGES];
	q30_t z_sk [CORDIC_STAGES];
	logic flip_sk [CORDIC_STAGES];
	q30_t sin_so, cos_so;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
		q30_t xi, yi, zi, at;
		logic fi;
		if (i == 0) begin : g_first
			assign xi = GAIN_Q30;
			assign yi = '0;
			assign zi = z_in;
			assign fi = flip_in;
		end else begin : g_next
			assign xi = x_sk[i-1];
			assign yi = y_sk[i-1];
			assign zi = z_sk[i-1];
			assign fi = flip_sk[i-1];
		end
		assign at = $signed({{(Q_W-ATAN_W){1'b0}}, atan_q30(i)});

		always_ff @(posedge clk) begin
			if (en[i]) begin
				if (!zi[Q_W-1]) begin
					x_sk[i] <= xi - (yi >>> i);
					y_sk[i] <= yi + (xi >>> i);
					z_sk[i] <= zi - at;
				end else begin
					x_sk[i] <= xi + (yi >>> i);
					y_sk[i] <= yi - (xi >>> i);
					z_sk[i] <= zi + at;
				end
				flip_sk[i] <= fi;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[CORDIC_STAGES]) begin
			sin_so <= flip_sk[CORDIC_STAGES-1] ? -y_sk[CORDIC_STAGES-1] : y_sk[CORDIC_STAGES-1];
			cos_so <= flip_sk[CORDIC_STAGES-1] ? -x_sk[CORDIC_STAGES-1] : x_sk[CORDIC_STAGES-1];
		end
	end

	assign sin_out = sin_so;
	assign cos_out = cos_so;

endmodule

### sv/ea2rm_matmul.sv
// Two-stage 3x3 Q30 matrix product: registered products, then rounded row sums.
`timescale 1ns / 1ps
module ea2rm_matmul (
	input  logic           clk,
	input  logic [1:0]     en,
	input  ea2rm_pkg::mat_t a,
	input  ea2rm_pkg::mat_t b,
	output ea2rm_pkg::mat_t r
);
	import ea2rm_pkg::*;

	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (Q_FRAC - 1);

	logic signed [PROD_W-1:0] prod_s1 [3][3][3];
	mat_t                     r_s2;
	logic signed [ACC_W-1:0]  acc [3][3];
	logic signed [ACC_W-1:0]  rnd [3][3];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 3; k++) begin
						prod_s1[i][j][k] <= a[i][k] * b[k][j];
					end
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				acc[i][j] = ACC_W'(prod_s1[i][j][0]) + ACC_W'(prod_s1[i][j][1])
					+ ACC_W'(prod_s1[i][j][2]);
				rnd[i][j] = (acc[i][j] + RND_HALF) >>> Q_FRAC;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					r_s2[i][j] <= rnd[i][j][Q_W-1:0];
				end
			end
		end
	end

	assign r = r_s2;

endmodule

### sv/euler_angles_to_rotation_matrix.sv
// Top level: Euler angles in, 3x3 rotation matrix out, fully pipelined.
//
// The angles channel takes one transaction of angle_x, angle_y and angle_z
// (degrees times 128, saturated to a half turn). The matrix channel returns
// one transaction of nine Q2.14 elements per input transaction, in order.
// The cfg channel writes rotation_order; codes 6 and 7 are ignored. Write it
// only while no transaction is in flight; cfg is always ready.
// The pipeline runs through radian conversion, the CORDIC iterations plus a
// sign stage, the two matrix products and output rounding. While the
// receiver keeps ready high, a new transaction is taken in every cycle and
// the throughput is one matrix per clock, set by the per-iteration CORDIC
// registers and the pipelined multipliers.
// Reset clears all valid bits and sets the order to xyz. When the receiver
// stalls, the result holds in the output register and stages behind it keep
// filling bubbles; ready drops only once every stage holds a transaction.
`timescale 1ns / 1ps
module euler_angles_to_rotation_matrix #(
	parameter int CORDIC_STAGES = ea2rm_pkg::CORDIC_STAGES_DEF,
	parameter int OUT_FRAC_BITS = ea2rm_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	ea2rm_cfg_if.sink      cfg,
	ea2rm_angle_if.sink    angles,
	ea2rm_matrix_if.source matrix
);
	import ea2rm_pkg::*;

	localparam int NST   = CORDIC_STAGES + 9;
	localparam int ST_CS = CORDIC_STAGES + 3;
	localparam int ST_M1 = CORDIC_STAGES + 4;
	localparam int ST_M2 = CORDIC_STAGES + 6;
	localparam int ST_OUT = CORDIC_STAGES + 8;
	localparam int SH    = Q_FRAC - OUT_FRAC_BITS;
	localparam logic signed [Q_W:0] RND_ADD = (SH > 0) ? ((Q_W+1)'(1) <<< (SH - 1)) : '0;
	localparam logic signed [Q_W:0] HI =
		(OUT_FRAC_BITS >= OUT_W - 1) ? (Q_W+1)'(32767) : ((Q_W+1)'(1) <<< OUT_FRAC_BITS);
	localparam logic signed [Q_W:0] LO = -HI - ((OUT_FRAC_BITS >= OUT_W - 1) ? 1 : 0);

	order_t           order_q;
	logic [NST-1:0]   vld_s;
	logic [NST:0]     en;
	order_t           ord_s [ST_CS+1];

	q30_t z [3];
	logic flip [3];
	q30_t sn [3];
	q30_t cs [3];

	mat_t rx, ry, rz, pm, qm, rm, t_mat, m_mat;
	mat_t r_sa, r_sb;
	logic signed [OUT_W-1:0] out_s [3][3];
	logic signed [Q_W:0]     rnd [3][3];
	logic signed [Q_W:0]     clp [3][3];

	// Configuration register.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORD_XYZ;
		end else if (cfg.valid && cfg.ready && (cfg.rotation_order <= ORD_XYZ)) begin
			order_q <= order_t'(cfg.rotation_order);
		end
	end

	// A stage advances when it is empty or the stage after it advances.
	always_comb begin
		en[NST] = matrix.ready;
		for (int k = NST - 1; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign angles.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (en[k]) begin
					vld_s[k] <= (k == 0) ? angles.valid : vld_s[(k == 0) ? 0 : k - 1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k <= ST_CS; k++) begin
			if (en[k]) begin
				ord_s[k] <= (k == 0) ? order_q : ord_s[(k == 0) ? 0 : k - 1];
			end
		end
	end

	ea2rm_rad u_rad_x (.clk(clk), .en(en[2:0]), .angle(angles.angle_x), .z(z[0]), .flip(flip[0]));
	ea2rm_rad u_rad_y (.clk(clk), .en(en[2:0]), .angle(angles.angle_y), .z(z[1]), .flip(flip[1]));
	ea2rm_rad u_rad_z (.clk(clk), .en(en[2:0]), .angle(angles.angle_z), .z(z[2]), .flip(flip[2]));

	for (genvar a = 0; a < 3; a++) begin : g_cordic
		ea2rm_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
			.clk     (clk),
			.en      (en[ST_CS:3]),
			.z_in    (z[a]),
			.flip_in (flip[a]),
			.sin_out (sn[a]),
			.cos_out (cs[a])
		);
	end

	// Elementary rotations and the order that picks the two products.
	always_comb begin
		rx = '{'{ONE_Q30, '0, '0}, '{'0, cs[0], -sn[0]}, '{'0, sn[0], cs[0]}};
		ry = '{'{cs[1], '0, sn[1]}, '{'0, ONE_Q30, '0}, '{-sn[1], '0, cs[1]}};
		rz = '{'{cs[2], -sn[2], '0}, '{sn[2], cs[2], '0}, '{'0, '0, ONE_Q30}};
		unique case (ord_s[ST_CS])
			ORD_ZYX: begin pm = rx; qm = ry; rm = rz; end
			ORD_YZX: begin pm = rx; qm = rz; rm = ry; end
			ORD_ZXY: begin pm = ry; qm = rx; rm = rz; end
			ORD_XZY: begin pm = ry; qm = rz; rm = rx; end
			ORD_YXZ: begin pm = rz; qm = rx; rm = ry; end
			default: begin pm = rz; qm = ry; rm = rx; end
		endcase
	end

	ea2rm_matmul u_mm_first (.clk(clk), .en(en[ST_M1+1:ST_M1]), .a(pm), .b(qm), .r(t_mat));

	always_ff @(posedge clk) begin
		if (en[ST_M1]) begin
			r_sa <= rm;
		end
		if (en[ST_M1+1]) begin
			r_sb <= r_sa;
		end
	end

	ea2rm_matmul u_mm_second (.clk(clk), .en(en[ST_M2+1:ST_M2]), .a(t_mat), .b(r_sb),
		.r(m_mat));

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				rnd[i][j] = ((Q_W+1)'(m_mat[i][j]) + RND_ADD) >>> SH;
				if (rnd[i][j] > HI) begin
					clp[i][j] = HI;
				end else if (rnd[i][j] < LO) begin
					clp[i][j] = LO;
				end else begin
					clp[i][j] = rnd[i][j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					out_s[i][j] <= clp[i][j][OUT_W-1:0];
				end
			end
		end
	end

	assign matrix.valid = vld_s[NST-1];
	assign matrix.m00   = out_s[0][0];
	assign matrix.m01   = out_s[0][1];
	assign matrix.m02   = out_s[0][2];
	assign matrix.m10   = out_s[1][0];
	assign matrix.m11   = out_s[1][1];
	assign matrix.m12   = out_s[1][2];
	assign matrix.m20   = out_s[2][0];
	assign matrix.m21   = out_s[2][1];
	assign matrix.m22   = out_s[2][2];

	// An empty output stage must never hold back the input.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[NST-1] |-> angles.ready)
		else $error("input stalled while the output stage is empty");

	// Out-of-range order codes leave the register untouched.
	a_bad_order_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.valid && cfg.ready && (cfg.rotation_order > ORD_XYZ)) |=> $stable(order_q))
		else $error("invalid rotation order was written");

	// The delivered diagonal elements lie within the saturation range, plus and minus one by default.
	a_out_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		matrix.valid |-> ((Q_W+1)'(matrix.m00) <= HI && (Q_W+1)'(matrix.m00) >= LO
			&& (Q_W+1)'(matrix.m11) <= HI && (Q_W+1)'(matrix.m11) >= LO
			&& (Q_W+1)'(matrix.m22) <= HI && (Q_W+1)'(matrix.m22) >= LO))
		else $error("matrix element outside the saturation range");

endmodule
